@@ rtl/core/secr_pkg.sv @@
// shared constants and types of the stx/etx crc frame receiver
package secr_pkg;

  localparam logic [7:0]  STX_CODE = 8'h02;
  localparam logic [7:0]  ETX_CODE = 8'h03;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_START_RESET = 16'hFFFF;

  localparam int CRC_BYTES = 2;
  localparam int PAYLOAD_W = 64;
  localparam int MAX_DATA_BYTES = PAYLOAD_W / 8;

  typedef enum logic [1:0] {
    STATUS_RUN  = 2'd0,
    STATUS_PASS = 2'd1,
    STATUS_FAIL = 2'd2
  } frame_status_t;

  typedef logic [15:0] crc_t;

endpackage

@@ rtl/core/secr_stream_if.sv @@
// valid/ready channel interfaces for received bytes and frame results
interface secr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rearm;

  modport source (output valid, output rx_byte, output rearm, input ready);
  modport sink   (input valid, input rx_byte, input rearm, output ready);
endinterface

interface secr_out_if;
  logic        valid;
  logic        ready;
  logic        byte_taken;
  logic [1:0]  frame_status;
  logic [63:0] frame_payload;

  modport source (output valid, output byte_taken, output frame_status,
                  output frame_payload, input ready);
  modport sink   (input valid, input byte_taken, input frame_status,
                  input frame_payload, output ready);
endinterface

@@ rtl/core/secr_crc_step.sv @@
// one byte fold of crc-16 msb-first, polynomial 0x1021
module secr_crc_step
  import secr_pkg::*;
(
  input  crc_t       crc_in,
  input  logic [7:0] data_in,
  output crc_t       crc_out
);

  always_comb begin
    crc_t c;
    c = crc_in ^ {data_in, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

@@ rtl/core/stx_etx_crc_frame_receiver_top.sv @@
// top level of the stx/etx framed receiver with crc-16 check
//
//  channel   | direction | fields
//  in_ch     | sink      | rx_byte[7:0], rearm
//  out_ch    | source    | byte_taken, frame_status[1:0], frame_payload[63:0]
//  cfg_*     | write     | cfg_wr_en, cfg_wr_data[15:0] (crc start value)
//
// one byte per cycle unless out_ch stalls; results appear in the next cycle
// the frame state and crc fold settle into the result register
// synchronous active-low reset: hunting for stx, start value 0xffff
// a stalled result register holds in_ch.ready low until out_ch takes it
module stx_etx_crc_frame_receiver_top
  import secr_pkg::*;
#(
  parameter int DATA_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  secr_in_if.sink           in_ch,
  secr_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data
);

  localparam int CNT_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_DATA,
    PH_CRC,
    PH_ETX,
    PH_PASS,
    PH_FAIL
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  crc_t                crc_r, crc_nxt;
  crc_t                crc_start_r;
  crc_t                crc_folded;
  logic [7:0]          store_r [DATA_BYTES];
  logic                store_we;

  logic                out_valid_r;
  logic                out_taken_r, out_taken_nxt;
  frame_status_t       out_status_r, out_status_nxt;
  logic [63:0]         out_payload_r, out_payload_nxt;
  logic [63:0]         packed_payload;
  logic                in_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  secr_crc_step u_crc_step (
    .crc_in  (crc_r),
    .data_in (in_ch.rx_byte),
    .crc_out (crc_folded)
  );

  always_comb begin
    packed_payload = '0;
    for (int i = 0; i < DATA_BYTES; i++) begin
      packed_payload[8*i +: 8] = store_r[i];
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    crc_nxt       = crc_r;
    store_we      = 1'b0;
    out_taken_nxt = 1'b0;
    if (in_ch.rearm) begin
      phase_nxt = PH_HUNT;
      cnt_nxt   = '0;
    end else begin
      case (phase_r)
        PH_HUNT: begin
          out_taken_nxt = 1'b1;
          if (in_ch.rx_byte == STX_CODE) begin
            phase_nxt = PH_DATA;
            cnt_nxt   = '0;
            crc_nxt   = crc_start_r;
          end
        end
        PH_DATA: begin
          out_taken_nxt = 1'b1;
          store_we      = 1'b1;
          crc_nxt       = crc_folded;
          if (cnt_r == CNT_W'(DATA_BYTES - 1)) begin
            phase_nxt = PH_CRC;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        PH_CRC: begin
          out_taken_nxt = 1'b1;
          crc_nxt       = crc_folded;
          if (cnt_r == CNT_W'(CRC_BYTES - 1)) begin
            phase_nxt = PH_ETX;
          end
          cnt_nxt = cnt_r + 1'b1;
        end
        PH_ETX: begin
          out_taken_nxt = 1'b1;
          if (in_ch.rx_byte == ETX_CODE && crc_r == '0) begin
            phase_nxt = PH_PASS;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_PASS, PH_FAIL: begin
          out_taken_nxt = 1'b0;
        end
        default: begin
          phase_nxt = PH_HUNT;
          cnt_nxt   = '0;
        end
      endcase
    end

    case (phase_nxt)
      PH_PASS: out_status_nxt = STATUS_PASS;
      PH_FAIL: out_status_nxt = STATUS_FAIL;
      default: out_status_nxt = STATUS_RUN;
    endcase
    out_payload_nxt = (out_status_nxt == STATUS_RUN) ? '0 : packed_payload;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_start_r  <= CRC_START_RESET;
      phase_r      <= PH_HUNT;
      cnt_r        <= '0;
      crc_r        <= '0;
      out_valid_r  <= 1'b0;
      out_taken_r  <= 1'b0;
      out_status_r <= STATUS_RUN;
    end else begin
      if (cfg_wr_en) begin
        crc_start_r <= cfg_wr_data;
      end
      if (in_fire) begin
        phase_r      <= phase_nxt;
        cnt_r        <= cnt_nxt;
        crc_r        <= crc_nxt;
        out_taken_r  <= out_taken_nxt;
        out_status_r <= out_status_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_payload_r <= out_payload_nxt;
    end
  end

  for (genvar g = 0; g < DATA_BYTES; g++) begin : g_store
    always_ff @(posedge clk) begin
      if (in_fire && store_we && cnt_r == CNT_W'(g)) begin
        store_r[g] <= in_ch.rx_byte;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.byte_taken    = out_taken_r;
  assign out_ch.frame_status  = out_status_r;
  assign out_ch.frame_payload = out_payload_r;

  a_held_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_ch.rearm && (phase_r == PH_PASS || phase_r == PH_FAIL)
    |=> out_valid_r && !out_taken_r && out_status_r != STATUS_RUN)
    else $error("held verdict consumed a byte");

  a_run_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == STATUS_RUN |-> out_payload_r == '0)
    else $error("payload shown while frame in progress");

  a_rearm_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.rearm
    |=> phase_r == PH_HUNT && cnt_r == '0 && !out_taken_r)
    else $error("rearm did not return to hunting");

  a_etx_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_ch.rearm && phase_r == PH_ETX
    |=> out_taken_r && out_status_r != STATUS_RUN)
    else $error("closing byte gave no verdict");

endmodule

@@ sim/stx_etx_crc_frame_receiver_top_tb.sv @@
// self-checking testbench of the stx/etx crc-16 frame receiver: directed table, then random frames
module stx_etx_crc_frame_receiver_top_tb;
  import secr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_BYTES  = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 220;

  typedef enum logic [2:0] {
    RX_HUNT,
    RX_DATA,
    RX_CRC,
    RX_ETX,
    RX_PASS,
    RX_FAIL
  } rx_phase_t;

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_CRC_HI,
    ROW_CRC_LO
  } row_kind_t;

  typedef struct {
    logic          taken;
    frame_status_t status;
    logic [63:0]   payload;
  } frame_result_t;

  typedef struct {
    row_kind_t     kind;
    logic [7:0]    rx_byte;
    logic          rearm;
    logic          typed;
    frame_result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;

  secr_in_if  in_if ();
  secr_out_if out_if ();

  stx_etx_crc_frame_receiver_top #(
    .DATA_BYTES(DATA_BYTES)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // receiver model state
  crc_t       crc_start;
  rx_phase_t  rx_phase;
  logic [3:0] rx_count;
  logic [7:0] payload_bytes [0:7];
  crc_t       crc_acc;
  crc_t       frame_crc;

  frame_result_t verdict_q [$];
  stim_row_t     stim_table [$];
  frame_result_t seen_want;

  int errors;
  int cycle_count;
  int sink_cycles;
  int burst_left;
  bit sender_steady;

  function automatic crc_t crc16_ccitt_fold(input crc_t crc, input logic [7:0] b);
    crc_t c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic frame_result_t frame_step(input logic [7:0] b, input logic rearm);
    frame_result_t res;
    res.taken   = 1'b0;
    res.status  = STATUS_RUN;
    res.payload = '0;
    if (rearm) begin
      rx_phase = RX_HUNT;
      rx_count = '0;
    end else begin
      case (rx_phase)
        RX_HUNT: begin
          res.taken = 1'b1;
          if (b == STX_CODE) begin
            rx_phase = RX_DATA;
            rx_count = '0;
            crc_acc  = crc_start;
          end
        end
        RX_DATA: begin
          res.taken = 1'b1;
          crc_acc = crc16_ccitt_fold(crc_acc, b);
          payload_bytes[rx_count[2:0]] = b;
          rx_count = rx_count + 1'b1;
          if (rx_count >= DATA_BYTES) begin
            rx_phase  = RX_CRC;
            rx_count  = '0;
            frame_crc = crc_acc;
          end
        end
        RX_CRC: begin
          res.taken = 1'b1;
          crc_acc = crc16_ccitt_fold(crc_acc, b);
          rx_count = rx_count + 1'b1;
          if (rx_count >= CRC_BYTES) begin
            rx_phase = RX_ETX;
          end
        end
        RX_ETX: begin
          res.taken = 1'b1;
          rx_phase = (b == ETX_CODE && crc_acc == '0) ? RX_PASS : RX_FAIL;
        end
        default: ;
      endcase
    end
    if (rx_phase == RX_PASS) begin
      res.status = STATUS_PASS;
    end else if (rx_phase == RX_FAIL) begin
      res.status = STATUS_FAIL;
    end
    if (res.status != STATUS_RUN) begin
      for (int i = 0; i < DATA_BYTES; i++) begin
        res.payload[8*i +: 8] = payload_bytes[i];
      end
    end
    return res;
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic [7:0] b,
                                  input logic rearm, input logic typed,
                                  input logic taken, input frame_status_t status);
    stim_row_t row;
    row.kind         = kind;
    row.rx_byte      = b;
    row.rearm        = rearm;
    row.typed        = typed;
    row.want.taken   = taken;
    row.want.status  = status;
    row.want.payload = '0;
    stim_table.push_back(row);
  endfunction

  // drives one transaction, waits for it to be taken and records its expected result
  task automatic send_byte(input logic [7:0] b, input logic rearm, input logic typed,
                           input frame_result_t typed_want);
    int gap;
    frame_result_t want;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    in_if.rearm   <= rearm;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    want = frame_step(b, rearm);
    if (typed) begin
      want = typed_want;
    end
    verdict_q.push_back(want);
  endtask

  task automatic write_crc_start(input crc_t value);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    crc_start = value;
  endtask

  task automatic run_random_frames(input int n);
    int count;
    int pick;
    logic [7:0] b;
    logic rearm;
    logic held;
    frame_result_t none;
    count = 0;
    none.taken   = 1'b0;
    none.status  = STATUS_RUN;
    none.payload = '0;
    while (count < n) begin
      b     = 8'($urandom_range(0, 255));
      rearm = 1'b0;
      pick  = $urandom_range(0, 99);
      case (rx_phase)
        RX_HUNT: begin
          if (pick < 60) begin
            b = STX_CODE;
          end else if (pick < 64) begin
            rearm = 1'b1;
          end
        end
        RX_DATA: begin
          if (pick < 2) begin
            rearm = 1'b1;
          end
        end
        RX_CRC: begin
          if (pick < 88) begin
            b = (rx_count == 0) ? frame_crc[15:8] : frame_crc[7:0];
          end else if (pick < 90) begin
            rearm = 1'b1;
          end
        end
        RX_ETX: begin
          if (pick < 85) begin
            b = ETX_CODE;
          end else if (pick < 87) begin
            rearm = 1'b1;
          end
        end
        default: begin
          if (pick < 70) begin
            rearm = 1'b1;
          end
        end
      endcase
      held = !rearm && (rx_phase == RX_PASS || rx_phase == RX_FAIL);
      send_byte(b, rearm, 1'b0, none);
      if (!held) begin
        count++;
      end
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: own stall pattern plus two long hold-offs
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      sink_cycles++;
      if ((sink_cycles >= 300 && sink_cycles < 380) ||
          (sink_cycles >= 1500 && sink_cycles < 1620)) begin
        out_if.ready <= 1'b0;
      end else begin
        case ((sink_cycles / 256) % 4)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 3) != 0);
          2: out_if.ready <= ((sink_cycles % 5) > 1);
          default: out_if.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result taken=%0b status=%0d payload=%h", $time,
                 out_if.byte_taken, out_if.frame_status, out_if.frame_payload);
        errors++;
      end else begin
        seen_want = verdict_q.pop_front();
        if (out_if.byte_taken !== seen_want.taken) begin
          $display("%0t: byte_taken expected %0b actual %0b", $time,
                   seen_want.taken, out_if.byte_taken);
          errors++;
        end
        if (out_if.frame_status !== seen_want.status) begin
          $display("%0t: frame_status expected %0d actual %0d", $time,
                   seen_want.status, out_if.frame_status);
          errors++;
        end
        if (out_if.frame_payload !== seen_want.payload) begin
          $display("%0t: frame_payload expected %h actual %h", $time,
                   seen_want.payload, out_if.frame_payload);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [7:0] b;
    crc_t start_values [5];
    errors        = 0;
    cycle_count   = 0;
    sink_cycles   = 0;
    burst_left    = 0;
    sender_steady = 1'b0;
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_if.valid   <= 1'b0;
    in_if.rx_byte <= '0;
    in_if.rearm   <= 1'b0;

    crc_start = CRC_START_RESET;
    rx_phase  = RX_HUNT;
    rx_count  = '0;
    crc_acc   = '0;
    frame_crc = '0;
    for (int i = 0; i < 8; i++) begin
      payload_bytes[i] = '0;
    end

    // noise and rearm while hunting, then a good frame held in pass
    add_row(ROW_BYTE, 8'h00, 1'b0, 1'b1, 1'b1, STATUS_RUN);
    add_row(ROW_BYTE, 8'hFF, 1'b1, 1'b1, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, STX_CODE, 1'b0, 1'b1, 1'b1, STATUS_RUN);
    add_row(ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, 8'h55, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, 8'hAA, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, STX_CODE, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, ETX_CODE, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, 8'h80, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, 8'h01, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_CRC_HI, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_CRC_LO, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, ETX_CODE, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, STX_CODE, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, 8'h00, 1'b1, 1'b1, 1'b0, STATUS_RUN);
    // second frame with good crc but a wrong closing byte
    add_row(ROW_BYTE, STX_CODE, 1'b0, 1'b1, 1'b1, STATUS_RUN);
    add_row(ROW_BYTE, 8'h5A, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, 8'hA5, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, 8'h0F, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, 8'hF0, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, 8'h12, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, 8'h34, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, 8'hC3, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, 8'h3C, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_CRC_HI, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_CRC_LO, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_RUN);
    add_row(ROW_BYTE, 8'h04, 1'b0, 1'b0, 1'b0, STATUS_RUN);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      case (stim_table[i].kind)
        ROW_CRC_HI: b = frame_crc[15:8];
        ROW_CRC_LO: b = frame_crc[7:0];
        default:    b = stim_table[i].rx_byte;
      endcase
      send_byte(b, stim_table[i].rearm, stim_table[i].typed, stim_table[i].want);
    end
    in_if.valid <= 1'b0;

    start_values[0] = 16'h0000;
    start_values[1] = 16'hFFFF;
    start_values[2] = 16'h1D0F;
    start_values[3] = 16'($urandom_range(0, 65535));
    start_values[4] = 16'($urandom_range(0, 65535));
    for (int p = 0; p < 5; p++) begin
      write_crc_start(start_values[p]);
      sender_steady = (p == 1);
      run_random_frames(PHASE_ITEMS);
    end

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ stx_etx_crc_frame_receiver_top.f @@
rtl/core/secr_pkg.sv
rtl/core/secr_stream_if.sv
rtl/core/secr_crc_step.sv
rtl/core/stx_etx_crc_frame_receiver_top.sv
sim/stx_etx_crc_frame_receiver_top_tb.sv
